// File: rtl/rcd_pkg.sv
package rcd_pkg;

  localparam int DEPTH  = 8;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INS_REAR  = 2'd0,
    OP_INS_FRONT = 2'd1,
    OP_DEL_FRONT = 2'd2,
    OP_DEL_REAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_UNDERFLOW   = 2'd2,
    ST_NOT_ALLOWED = 2'd3
  } status_t;

  typedef enum logic {
    MODE_IN_RESTRICTED  = 1'b0,
    MODE_OUT_RESTRICTED = 1'b1
  } mode_t;

  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_rear;
    logic pop_rear;
  } cell_cmd_t;

endpackage

// File: rtl/restricted_circular_deque.sv
// Channel   Ports                                          Dir   Transfer when
// input     in_valid in_stall in_operation in_value_in     in    in_valid & !in_stall
// result    out_valid out_stall out_status out_value_out   out   out_valid & !out_stall
// config    cfg_wr_en cfg_wr_data                          in    cfg_wr_en
//
// One item per cycle while in_stall is low; its result is registered and shows in the cycle after the transfer.
// The row of slot cells shifts as a whole on front inserts and deletes, so every
// operation completes in the cycle of its transfer.
// Reset (rst_n low, synchronous) empties the queue and sets input-restricted mode.
// in_stall is high only while a result waits and out_stall is high.
module restricted_circular_deque (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic signed [rcd_pkg::DATA_W-1:0] in_value_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [rcd_pkg::DATA_W-1:0] out_value_out,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);

  localparam int N = rcd_pkg::DEPTH;

  logic [N-1:0]                      cell_vld;
  logic [N-1:0]                      vld_inc;
  logic [N-1:0]                      cell_rear;
  logic signed [rcd_pkg::DATA_W-1:0] cell_data [N];
  logic [N-1:0]                      lft_vld;
  logic signed [rcd_pkg::DATA_W-1:0] lft_data  [N];
  logic [N-1:0]                      rgt_vld;
  logic signed [rcd_pkg::DATA_W-1:0] rgt_data  [N];
  logic signed [rcd_pkg::DATA_W-1:0] rear_data;

  rcd_pkg::cell_cmd_t                cmd;
  rcd_pkg::op_t                      op;
  rcd_pkg::mode_t                    mode_r;
  rcd_pkg::status_t                  status;
  logic signed [rcd_pkg::DATA_W-1:0] value;
  logic                              acc;
  logic                              empty;
  logic                              full;
  logic                              done;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  rcd_pkg::status_t                  out_status_r;
  logic signed [rcd_pkg::DATA_W-1:0] out_value_r;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign op       = rcd_pkg::op_t'(in_operation);
  assign empty    = !cell_vld[0];
  assign full     = cell_vld[N-1];
  assign vld_inc  = cell_vld + N'(1);

  // neighbor links: the front cell sees the incoming value as a valid left neighbor
  always_comb begin
    lft_vld[0]    = 1'b1;
    lft_data[0]   = in_value_in;
    rgt_vld[N-1]  = 1'b0;
    rgt_data[N-1] = '0;
    for (int i = 1; i < N; i++) begin
      lft_vld[i]    = cell_vld[i-1];
      lft_data[i]   = cell_data[i-1];
      rgt_vld[i-1]  = cell_vld[i];
      rgt_data[i-1] = cell_data[i];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    rcd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .ins_value (in_value_in),
      .lft_vld   (lft_vld[g]),
      .lft_data  (lft_data[g]),
      .rgt_vld   (rgt_vld[g]),
      .rgt_data  (rgt_data[g]),
      .vld       (cell_vld[g]),
      .data      (cell_data[g]),
      .is_rear   (cell_rear[g])
    );
  end

  always_comb begin
    rear_data = '0;
    for (int i = 0; i < N; i++) begin
      rear_data = rear_data | (cell_data[i] & {rcd_pkg::DATA_W{cell_rear[i]}});
    end
  end

  always_comb begin
    status = rcd_pkg::ST_DONE;
    value  = '0;
    if ((mode_r == rcd_pkg::MODE_IN_RESTRICTED  && op == rcd_pkg::OP_INS_FRONT) ||
        (mode_r == rcd_pkg::MODE_OUT_RESTRICTED && op == rcd_pkg::OP_DEL_REAR)) begin
      status = rcd_pkg::ST_NOT_ALLOWED;
    end else begin
      case (op)
        rcd_pkg::OP_INS_REAR, rcd_pkg::OP_INS_FRONT: begin
          if (full) status = rcd_pkg::ST_OVERFLOW;
        end
        rcd_pkg::OP_DEL_FRONT: begin
          if (empty) status = rcd_pkg::ST_UNDERFLOW;
          else       value  = cell_data[0];
        end
        rcd_pkg::OP_DEL_REAR: begin
          if (empty) status = rcd_pkg::ST_UNDERFLOW;
          else       value  = rear_data;
        end
        default: status = rcd_pkg::ST_DONE;
      endcase
    end
  end

  assign done           = acc && (status == rcd_pkg::ST_DONE);
  assign cmd.push_rear  = done && (op == rcd_pkg::OP_INS_REAR);
  assign cmd.push_front = done && (op == rcd_pkg::OP_INS_FRONT);
  assign cmd.pop_front  = done && (op == rcd_pkg::OP_DEL_FRONT);
  assign cmd.pop_rear   = done && (op == rcd_pkg::OP_DEL_REAR);

  assign out_valid_nxt = acc || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= rcd_pkg::MODE_IN_RESTRICTED;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) mode_r <= rcd_pkg::mode_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= status;
      out_value_r  <= value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

  a_vld_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_vld & vld_inc) == '0)
    else $error("occupied cells are not contiguous from the front");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_rear || cmd.push_front) |=>
      $countones(cell_vld) == $past($countones(cell_vld)) + 1)
    else $error("successful insert did not add one element");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_rear || cmd.pop_front) |=>
      $countones(cell_vld) + 1 == $past($countones(cell_vld)))
    else $error("successful delete did not remove one element");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && status == rcd_pkg::ST_UNDERFLOW) |-> cell_vld == '0)
    else $error("underflow reported on a non-empty queue");

  a_single_rear: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_rear))
    else $error("more than one rear cell");

endmodule

// File: rtl/rcd_cell.sv
module rcd_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rcd_pkg::cell_cmd_t                cmd,
  input  logic signed [rcd_pkg::DATA_W-1:0] ins_value,
  input  logic                              lft_vld,
  input  logic signed [rcd_pkg::DATA_W-1:0] lft_data,
  input  logic                              rgt_vld,
  input  logic signed [rcd_pkg::DATA_W-1:0] rgt_data,
  output logic                              vld,
  output logic signed [rcd_pkg::DATA_W-1:0] data,
  output logic                              is_rear
);

  logic                              vld_r;
  logic                              vld_nxt;
  logic signed [rcd_pkg::DATA_W-1:0] data_r;
  logic signed [rcd_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (cmd.push_front) begin
      vld_nxt  = lft_vld;
      data_nxt = lft_data;
    end else if (cmd.pop_front) begin
      vld_nxt  = rgt_vld;
      data_nxt = rgt_data;
    end else if (cmd.push_rear && lft_vld && !vld_r) begin
      vld_nxt  = 1'b1;
      data_nxt = ins_value;
    end else if (cmd.pop_rear && vld_r && !rgt_vld) begin
      vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign vld     = vld_r;
  assign data    = data_r;
  assign is_rear = vld_r && !rgt_vld;

endmodule
